/* hdl/tmf_pkg.sv */
// ----------------------------------------------------------------------------
// tmf_pkg
// Shared constants and types for the multichannel trimmed mean unit.
// ----------------------------------------------------------------------------
package tmf_pkg;

  localparam int CHANNELS    = 2;
  localparam int KEEP_LOG2   = 3;
  localparam int SAMPLE_BITS = 12;

  // Fixed field widths of the ports
  localparam int IN_BITS     = 12;
  localparam int CHAN_BITS   = 3;
  localparam int AVG_BITS    = 12;
  localparam logic [AVG_BITS-1:0] AVG_MAX = '1;

  localparam int ROUNDS      = (1 << KEEP_LOG2) + 2;
  localparam int RND_BITS    = $clog2(ROUNDS);
  localparam int PTR_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  // The sum holds ROUNDS full-scale samples without wrapping
  localparam int SUM_BITS    = SAMPLE_BITS + $clog2(ROUNDS);
  localparam int SHIFT_BITS  = (SUM_BITS > AVG_BITS) ? SUM_BITS : AVG_BITS;

  localparam logic [PTR_BITS-1:0] LAST_CHAN  = PTR_BITS'(CHANNELS - 1);
  localparam logic [RND_BITS-1:0] LAST_ROUND = RND_BITS'(ROUNDS - 1);

  typedef struct packed {
    logic [SUM_BITS-1:0]    sum;
    logic [SAMPLE_BITS-1:0] min;
    logic [SAMPLE_BITS-1:0] max;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

endpackage

/* hdl/tmf_ram.sv */
// ----------------------------------------------------------------------------
// tmf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH>1?DEPTH:2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic [$clog2(DEPTH>1?DEPTH:2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/tmf_datapath.sv */
// ----------------------------------------------------------------------------
// tmf_datapath
// Entry update (sum, min, max) and trimmed average of one channel entry.
// ----------------------------------------------------------------------------
module tmf_datapath
  import tmf_pkg::*;
(
  input  entry_t                 rd_entry,
  input  logic [SAMPLE_BITS-1:0] sample_q,
  input  logic                   first_round,
  output entry_t                 wr_entry,
  output logic [AVG_BITS-1:0]    average_calc
);

  logic [SUM_BITS-1:0]   trimmed;
  logic [SHIFT_BITS-1:0] shifted;

  // Load on the first round of a set, accumulate afterwards
  always_comb begin
    if (first_round) begin
      wr_entry.sum = SUM_BITS'(sample_q);
      wr_entry.min = sample_q;
      wr_entry.max = sample_q;
    end else begin
      wr_entry.sum = rd_entry.sum + SUM_BITS'(sample_q);
      wr_entry.min = (sample_q < rd_entry.min) ? sample_q : rd_entry.min;
      wr_entry.max = (sample_q > rd_entry.max) ? sample_q : rd_entry.max;
    end
  end

  // Drop both extremes, divide by the kept count, clamp to the field
  always_comb begin
    trimmed = rd_entry.sum - SUM_BITS'(rd_entry.min) - SUM_BITS'(rd_entry.max);
    shifted = SHIFT_BITS'(trimmed >> KEEP_LOG2);
    if (shifted > SHIFT_BITS'(AVG_MAX)) begin
      average_calc = AVG_MAX;
    end else begin
      average_calc = shifted[AVG_BITS-1:0];
    end
  end

endmodule

/* hdl/multichannel_trimmed_mean_unit.sv */
// ----------------------------------------------------------------------------
// multichannel_trimmed_mean_unit
// Per-channel olympic trimmed mean over a set of scan rounds.
// ----------------------------------------------------------------------------
// Each sample's entry is read in S_IDLE and written back in S_UPDATE; no
// new sample is taken before that write-back. At the end of a set, each
// channel result passes S_READ, S_CALC and S_OUT, plus any wait on
// out_ready; no sample is taken during that burst.
// Reset clears the channel pointer, round counter and sequencer; the RAM
// needs no clearing pass since the first round of a set overwrites it.
// ----------------------------------------------------------------------------
module multichannel_trimmed_mean_unit
  import tmf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [IN_BITS-1:0]   sample,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CHAN_BITS-1:0] channel,
  output logic [AVG_BITS-1:0]  average,
  output logic                 last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_READ,
    S_CALC,
    S_OUT
  } state_t;

  state_t                 state;
  logic [PTR_BITS-1:0]    chan_ptr;
  logic [RND_BITS-1:0]    round;
  logic [PTR_BITS-1:0]    emit_idx;
  logic [SAMPLE_BITS-1:0] sample_q;

  logic [PTR_BITS-1:0]    rd_addr;
  logic                   wr_en;
  entry_t                 rd_entry;
  entry_t                 wr_entry;
  logic [ENTRY_BITS-1:0]  rd_data;
  logic [AVG_BITS-1:0]    average_calc;

  assign in_ready = (state == S_IDLE);
  assign wr_en    = (state == S_UPDATE);
  assign rd_entry = entry_t'(rd_data);

  // Read the accepted sample's channel while idle, the result entry otherwise
  assign rd_addr = (state == S_IDLE) ? chan_ptr : emit_idx;

  tmf_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (chan_ptr),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tmf_datapath u_datapath (
    .rd_entry     (rd_entry),
    .sample_q     (sample_q),
    .first_round  (round == '0),
    .wr_entry     (wr_entry),
    .average_calc (average_calc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      chan_ptr  <= '0;
      round     <= '0;
      emit_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          // Hold the sample; its entry read is already under way
          if (in_valid) begin
            sample_q <= SAMPLE_BITS'(sample);
            state    <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          // Write back the entry, then advance pointer and round
          if (chan_ptr == LAST_CHAN) begin
            chan_ptr <= '0;
            if (round == LAST_ROUND) begin
              round    <= '0;
              emit_idx <= '0;
              state    <= S_READ;
            end else begin
              round <= round + 1'b1;
              state <= S_IDLE;
            end
          end else begin
            chan_ptr <= chan_ptr + 1'b1;
            state    <= S_IDLE;
          end
        end
        S_READ: begin
          state <= S_CALC;
        end
        S_CALC: begin
          // Load the result register from the entry just read
          channel   <= CHAN_BITS'(emit_idx);
          average   <= average_calc;
          last      <= (emit_idx == LAST_CHAN);
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          // Hold the result until the transaction completes
          if (out_ready) begin
            out_valid <= 1'b0;
            if (emit_idx == LAST_CHAN) begin
              state <= S_IDLE;
            end else begin
              emit_idx <= emit_idx + 1'b1;
              state    <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
